>>> src/bfki_pkg.sv
// Package for the bloom filter k-mer insert block.
// Holds payload structs, hash constants and config index constants; no dependencies.
package bfki_pkg;

  typedef struct packed {
    logic [7:0] kmer_byte;
    logic       kmer_last;
  } req_t;

  typedef struct packed {
    logic [16:0] bits_set;
    logic        kmer_too_long;
  } rsp_t;

  localparam logic [31:0] XP1 = 32'd2654435761;
  localparam logic [31:0] XP2 = 32'd2246822519;
  localparam logic [31:0] XP3 = 32'd3266489917;
  localparam logic [31:0] XP4 = 32'd668265263;
  localparam logic [31:0] XP5 = 32'd374761393;

  localparam logic [0:0] CFG_BIT_COUNT  = 1'b0;
  localparam logic [0:0] CFG_HASH_COUNT = 1'b1;

endpackage

>>> src/bloom_filter_kmer_insert.sv
// Bloom filter k-mer insert: buffers k-mer bytes, hashes with XXH32 per seed,
// sets filter bits and reports the set-bit count. Depends on bfki_pkg.
//
// Usage: bytes arrive on in_valid/in_ready as requests (req_t). A byte with
// kmer_last low is stored and gives no result. On a last byte the block
// runs XXH32 once per seed 0..min(hash_count,16)-1 on a single shared
// 32x32 multiplier under a sequencer. Each 4-byte word goes through load,
// four byte reads, multiply, add and rotate/multiply, each tail byte through
// the same steps with one byte read, and each seed adds setup, finalization,
// a 32-step restoring remainder by bit_count_in_use (clamped to 1..FILTER_BITS)
// and the read/test/write of the bit store. An overlong k-mer gives its
// result without hashing. The result (rsp_t) is held in an output register
// until out_ready; the next request is taken only after the result is
// delivered. in_ready is low while hashing. Reset clears the k-mer state
// and count, then sweeps the bit store one word of 32 bits per cycle with
// in_ready low. Config writes (cfg_we, cfg_index, cfg_data) are taken at
// any time and should be made only while idle.
module bloom_filter_kmer_insert
  import bfki_pkg::*;
#(
  parameter int FILTER_BITS    = 65536,
  parameter int MAX_KMER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int LW  = $clog2(MAX_KMER_BYTES + 1);
  localparam int BA  = (MAX_KMER_BYTES > 1) ? $clog2(MAX_KMER_BYTES) : 1;
  localparam int WD  = (FILTER_BITS + 31) / 32;
  localparam int WA  = (WD > 1) ? $clog2(WD) : 1;
  localparam int FB  = $clog2(FILTER_BITS + 1);
  localparam int IW  = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;

  localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_INIT = 5'd2,
                         S_LD   = 5'd3,  S_RD   = 5'd4,  S_ADD  = 5'd5,
                         S_MUL  = 5'd6,  S_LANE = 5'd7,  S_MRG  = 5'd8,
                         S_F1   = 5'd9,  S_F2   = 5'd10, S_F3   = 5'd11,
                         S_F4   = 5'd12, S_MOD  = 5'd13, S_BRD  = 5'd14,
                         S_BWR  = 5'd15, S_OUT  = 5'd16, S_F5   = 5'd17;

  // config registers
  logic [16:0] bit_count_in_use;
  logic [4:0]  hash_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count_in_use <= 17'd65536;
      hash_count       <= 5'd7;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BIT_COUNT) bit_count_in_use <= cfg_data;
      else hash_count <= cfg_data[4:0];
    end
  end

  // memories
  logic [7:0]  kbuf [MAX_KMER_BYTES];
  logic [31:0] fmem [WD];

  logic [4:0]    state;
  logic [LW-1:0] klen;
  logic          overlong;
  logic [FB-1:0] total;
  logic [WA-1:0] clr_addr;
  logic [4:0]    seed, nh;
  logic [31:0]   nbits;
  logic [LW-1:0] pos;        // next byte to consume
  logic [1:0]    ph;         // 0 stripe, 1 tail word, 2 tail byte
  logic [1:0]    lane;
  logic [1:0]    bcnt;
  logic [31:0]   word, acc, h;
  logic [31:0]   v [4];
  logic [7:0]    rbyte;
  logic [5:0]    mstep;
  logic [32:0]   rem;
  logic [31:0]   quo;
  logic [31:0]   fword;
  logic [4:0]    fbit;
  logic [31:0]   ma, mb;
  logic [31:0]   prod;
  logic          nstripe;

  assign prod = ma * mb;
  assign in_ready = (state == S_IDLE) && !out_valid;

  // byte buffer write and read
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && klen < LW'(MAX_KMER_BYTES))
      kbuf[klen[BA-1:0]] <= in_data.kmer_byte;
    rbyte <= kbuf[pos[BA-1:0] + BA'(bcnt)];
  end

  logic [LW:0] rem_len;
  assign rem_len = {1'b0, klen} - {1'b0, pos};

  logic [IW-1:0] bidx;
  assign bidx = rem[IW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      klen      <= '0;
      overlong  <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          fmem[clr_addr] <= '0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WA'(WD - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (klen < LW'(MAX_KMER_BYTES)) klen <= klen + 1'b1;
            else overlong <= 1'b1;
            if (in_data.kmer_last) begin
              nh    <= (hash_count > 5'd16) ? 5'd16 : hash_count;
              nbits <= (bit_count_in_use == 17'd0) ? 32'd1 :
                       (32'(bit_count_in_use) > 32'(FILTER_BITS)) ? 32'(FILTER_BITS)
                       : 32'(bit_count_in_use);
              seed  <= '0;
              state <= (overlong || klen >= LW'(MAX_KMER_BYTES)) ? S_OUT : S_INIT;
            end
          end
        end
        S_INIT: begin
          if (seed >= nh) state <= S_OUT;
          else begin
            v[0] <= 32'(seed) + XP1 + XP2;
            v[1] <= 32'(seed) + XP2;
            v[2] <= 32'(seed);
            v[3] <= 32'(seed) - XP1;
            pos  <= '0;
            lane <= '0;
            if (klen >= LW'(16)) begin
              ph <= 2'd0; state <= S_LD;
            end else begin
              h <= 32'(seed) + XP5 + 32'(klen);
              ph <= 2'd1; state <= S_LD;
            end
            bcnt <= '0;
          end
        end
        // gather bytes of a word (or one byte in tail byte phase)
        S_LD: begin
          if (ph == 2'd1 && rem_len < (LW + 1)'(4)) begin
            ph <= 2'd2;
            if (rem_len == '0) state <= S_F1;
            else begin
              bcnt <= '0;
              state <= S_RD;
            end
          end else if (ph == 2'd2 && rem_len == '0) state <= S_F1;
          else begin
            bcnt <= '0;
            state <= S_RD;
          end
        end
        // rbyte is registered from the address given by bcnt, so S_RD waits for it
        S_RD: begin
          state <= S_ADD;
        end
        S_ADD: begin
          word <= {rbyte, word[31:8]};
          if (ph != 2'd2 && bcnt != 2'd3) begin
            bcnt <= bcnt + 1'b1; state <= S_RD;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // input word (or tail byte) * prime
          acc <= prod;
          state <= S_LANE;
        end
        S_LANE: begin
          unique case (ph)
            2'd0: acc <= v[lane] + acc;
            2'd1: acc <= h + acc;
            default: acc <= h + acc;
          endcase
          state <= S_MRG;
        end
        S_MRG: begin
          unique case (ph)
            2'd0: begin
              v[lane] <= prod;
              lane <= lane + 1'b1;
              pos <= pos + LW'(4);
              if (lane == 2'd3 && nstripe) state <= S_LD;
              else if (lane == 2'd3) begin
                h <= {v[0][30:0], v[0][31]} + {v[1][24:0], v[1][31:25]} +
                     {v[2][19:0], v[2][31:20]} + {prod[13:0], prod[31:14]} +
                     32'(klen);
                ph <= 2'd1; state <= S_LD;
              end else state <= S_LD;
            end
            2'd1: begin h <= prod; pos <= pos + LW'(4); state <= S_LD; end
            default: begin h <= prod; pos <= pos + 1'b1; state <= S_LD; end
          endcase
        end
        S_F1: begin h <= h ^ (h >> 15); state <= S_F2; end
        S_F2: begin h <= prod ^ (prod >> 13); state <= S_F3; end
        S_F3: begin h <= prod; state <= S_F5; end
        S_F5: begin
          h <= h ^ (h >> 16); rem <= '0; quo <= h ^ (h >> 16);
          mstep <= '0; state <= S_F4;
        end
        S_F4: begin state <= S_MOD; end
        // restoring remainder, one bit per cycle
        S_MOD: begin
          if ({rem[31:0], quo[31]} >= {1'b0, nbits})
            rem <= {rem[31:0], quo[31]} - {1'b0, nbits};
          else rem <= {rem[31:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
          mstep <= mstep + 1'b1;
          if (mstep == 6'd31) state <= S_BRD;
        end
        S_BRD: begin
          fword <= fmem[WA'(bidx >> 5)];
          fbit  <= 5'(bidx);
          state <= S_BWR;
        end
        S_BWR: begin
          if (!fword[fbit]) begin
            fmem[WA'(bidx >> 5)] <= fword | (32'd1 << fbit);
            total <= total + 1'b1;
          end
          seed <= seed + 1'b1;
          state <= S_INIT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data.bits_set <= 17'(total);
          out_data.kmer_too_long <= overlong || klen > LW'(MAX_KMER_BYTES)
                                    || (klen == LW'(MAX_KMER_BYTES) && overlong);
          klen <= '0;
          overlong <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stripe loop continues while another 16 bytes remain after this one
  assign nstripe = (rem_len >= (LW + 1)'(20));

  // shared multiplier operand select
  always_comb begin
    ma = h;
    mb = XP2;
    unique case (state)
      S_MUL: begin
        ma = word;
        if (ph == 2'd0) mb = XP2;
        else if (ph == 2'd1) mb = XP3;
        else begin ma = {24'd0, word[31:24]}; mb = XP5; end
      end
      S_MRG: begin
        unique case (ph)
          2'd0: begin ma = {acc[18:0], acc[31:19]}; mb = XP1; end
          2'd1: begin ma = {acc[14:0], acc[31:15]}; mb = XP4; end
          default: begin ma = {acc[20:0], acc[31:21]}; mb = XP1; end
        endcase
      end
      S_F2: begin ma = h; mb = XP2; end
      S_F3: begin ma = h; mb = XP3; end
      default: begin ma = h; mb = XP2; end
    endcase
  end

endmodule
